// ----- design/lgt_pkg.sv -----
`timescale 1ns / 1ps
// Package for longest_gap_tracker: sizes, status codes, FSM state type.
// No dependencies.
package lgt_pkg;
    localparam int MAX_CUTS = 1024;
    localparam int ADDR_W   = $clog2(MAX_CUTS);
    localparam int CNT_W    = $clog2(MAX_CUTS + 1);

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        F_IDLE,
        F_SRCH_RD,
        F_SRCH_CHK,
        F_DUP_CHK,
        F_SHIFT_RD,
        F_SHIFT_WR,
        F_SCAN_RD,
        F_SCAN_CHK,
        F_OUT
    } t_state;
endpackage

// ----- design/longest_gap_tracker.sv -----
`timescale 1ns / 1ps
// Longest gap tracker: sorted cut store in one 1-port-read/1-port-write RAM.
// Flow: a zero or out-of-range position goes straight to the result; otherwise a binary
//   search finds the insertion point, then, unless the cut is a duplicate or the store is
//   full, the entries above it are shifted up and all stored cuts are rescanned for the gap.
//   One transaction at a time; the next is accepted only once the result is taken.
// Reset (synchronous, active low): no cuts, track length 1, longest gap 1.
// Cut RAM contents are not cleared; only entries below the cut count are used.
module longest_gap_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_start_new,
    input  logic [31:0] i_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_longest_gap,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = lgt_pkg::ADDR_W;
    localparam int CW = lgt_pkg::CNT_W;
    localparam logic [CW-1:0] MAXC = CW'(lgt_pkg::MAX_CUTS);

    logic [31:0] mem [lgt_pkg::MAX_CUTS];
    logic [31:0] r_rd_data;

    lgt_pkg::t_state r_state, n_state;
    logic [31:0] r_len, r_longest, r_pos, r_prev, r_best;
    logic [CW-1:0] r_count, r_lo, r_hi, r_mid, r_k;
    logic [1:0] r_status;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;
    logic [CW-1:0] mid;
    logic [31:0]   gap, tail;
    logic          in_acc, out_acc;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign gap     = r_rd_data - r_prev;
    assign tail    = r_len - r_prev;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgt_pkg::F_IDLE: begin
                if (in_acc) begin
                    if (i_position == 32'd0 || i_position >= r_len) n_state = lgt_pkg::F_OUT;
                    else n_state = lgt_pkg::F_SRCH_RD;
                end
            end
            lgt_pkg::F_SRCH_RD:
                n_state = (r_lo < r_hi) ? lgt_pkg::F_SRCH_CHK : lgt_pkg::F_DUP_CHK;
            lgt_pkg::F_SRCH_CHK: n_state = lgt_pkg::F_SRCH_RD;
            lgt_pkg::F_DUP_CHK: begin
                if ((r_lo < r_count && r_rd_data == r_pos) || r_count == MAXC)
                    n_state = lgt_pkg::F_OUT;
                else
                    n_state = lgt_pkg::F_SHIFT_RD;
            end
            lgt_pkg::F_SHIFT_RD:
                n_state = (r_k > r_lo) ? lgt_pkg::F_SHIFT_WR : lgt_pkg::F_SCAN_RD;
            lgt_pkg::F_SHIFT_WR: n_state = lgt_pkg::F_SHIFT_RD;
            lgt_pkg::F_SCAN_RD:
                n_state = (r_k < r_count) ? lgt_pkg::F_SCAN_CHK : lgt_pkg::F_OUT;
            lgt_pkg::F_SCAN_CHK: n_state = lgt_pkg::F_SCAN_RD;
            lgt_pkg::F_OUT: if (out_acc) n_state = lgt_pkg::F_IDLE;
            default: n_state = lgt_pkg::F_IDLE;
        endcase
    end

    // outputs and RAM controls; a length write takes the idle cycle, input waits
    always_comb begin
        o_stall     = (r_state != lgt_pkg::F_IDLE) || i_cfg_valid;
        o_cfg_ready = (r_state == lgt_pkg::F_IDLE);
        o_valid     = (r_state == lgt_pkg::F_OUT);
        mem_re      = 1'b0;
        mem_ra      = '0;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = r_rd_data;
        case (r_state)
            lgt_pkg::F_SRCH_RD: begin
                mem_re = 1'b1;
                mem_ra = (r_lo < r_hi) ? mid[AW-1:0] : r_lo[AW-1:0];
            end
            lgt_pkg::F_SHIFT_RD: begin
                if (r_k > r_lo) begin
                    mem_re = 1'b1;
                    mem_ra = AW'(r_k - 1'b1);
                end else begin
                    mem_we = 1'b1;
                    mem_wa = r_lo[AW-1:0];
                    mem_wd = r_pos;
                end
            end
            lgt_pkg::F_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_wa = r_k[AW-1:0];
            end
            lgt_pkg::F_SCAN_RD: begin
                mem_re = (r_k < r_count);
                mem_ra = r_k[AW-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        if (mem_re) r_rd_data <= mem[mem_ra];
    end

    assign o_longest_gap = r_longest;
    assign o_status      = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lgt_pkg::F_IDLE;
            r_len     <= 32'd1;
            r_longest <= 32'd1;
            r_count   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                lgt_pkg::F_IDLE: begin
                    if (i_cfg_valid) begin
                        r_len     <= i_cfg_data;
                        r_longest <= i_cfg_data;
                        r_count   <= '0;
                    end else if (in_acc) begin
                        r_pos    <= i_position;
                        r_lo     <= '0;
                        r_hi     <= i_start_new ? '0 : r_count;
                        r_status <= lgt_pkg::ST_IGNORED;
                        if (i_start_new) begin
                            r_count   <= '0;
                            r_longest <= r_len;
                        end
                    end
                end
                lgt_pkg::F_SRCH_RD: r_mid <= mid;
                lgt_pkg::F_SRCH_CHK: begin
                    if (r_rd_data < r_pos) r_lo <= r_mid + 1'b1;
                    else r_hi <= r_mid;
                end
                lgt_pkg::F_DUP_CHK: begin
                    r_k <= r_count;
                    if (r_lo < r_count && r_rd_data == r_pos) r_status <= lgt_pkg::ST_IGNORED;
                    else if (r_count == MAXC) r_status <= lgt_pkg::ST_FULL;
                    else r_status <= lgt_pkg::ST_INSERTED;
                end
                lgt_pkg::F_SHIFT_RD: begin
                    if (!(r_k > r_lo)) begin
                        r_count <= r_count + 1'b1;
                        r_k     <= '0;
                        r_prev  <= '0;
                        r_best  <= '0;
                    end
                end
                lgt_pkg::F_SHIFT_WR: r_k <= r_k - 1'b1;
                lgt_pkg::F_SCAN_RD: begin
                    if (!(r_k < r_count))
                        r_longest <= (tail > r_best) ? tail : r_best;
                end
                lgt_pkg::F_SCAN_CHK: begin
                    if (gap > r_best) r_best <= gap;
                    r_prev <= r_rd_data;
                    r_k    <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXC) else $error("cut count above capacity");
    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |=> (r_state == lgt_pkg::F_IDLE)) else $error("no return to idle");
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && r_status == lgt_pkg::ST_INSERTED) |-> (r_count != '0))
        else $error("inserted cut but store empty");
`endif
endmodule
